/* rtl/faa_pkg.sv */
// Shared types, codes and constants of the fall alert annunciator.
`timescale 1ns / 1ps

package faa_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned SecsW = 23;
  localparam int unsigned HoldW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NEAR_LATCH = 3'd0,
    CFG_BUZZ_DELAY = 3'd1,
    CFG_BUZZ_ON    = 3'd2,
    CFG_BUZZ_STEP  = 3'd3,
    CFG_BUZZ_SLOW  = 3'd4,
    CFG_LED_REAL   = 3'd5,
    CFG_LED_NEAR   = 3'd6,
    CFG_ACK_HOLD   = 3'd7
  } cfg_idx_e;

  localparam logic [1:0] EVT_NEAR = 2'd1;
  localparam logic [1:0] EVT_REAL = 2'd2;

  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_NEAR = 2'd1;
  localparam logic [1:0] LVL_REAL = 2'd2;

  localparam logic [15:0] NEAR_LATCH_RST = 16'd2000;
  localparam logic [15:0] BUZZ_DELAY_RST = 16'd5000;
  localparam logic [15:0] BUZZ_ON_RST    = 16'd120;
  localparam logic [15:0] BUZZ_STEP_RST  = 16'd10000;
  localparam logic [15:0] BUZZ_SLOW_RST  = 16'd400;
  localparam logic [15:0] LED_REAL_RST   = 16'd200;
  localparam logic [15:0] LED_NEAR_RST   = 16'd600;
  localparam logic [HoldW-1:0] ACK_HOLD_RST = 4'd10;

  localparam logic [15:0] OFF_MID_MS  = 16'd200;
  localparam logic [15:0] OFF_FAST_MS = 16'd80;

  // Division by 1000 as a multiplication by the rounded-up value of 2^38 / 1000, a scaled reciprocal of 1000.
  localparam int unsigned DivMulW = 29;
  localparam logic [DivMulW-1:0] DIV_MUL = 29'd274877907;
  localparam int unsigned DivShift = 38;
  localparam int unsigned ProdW = TimeW + DivMulW;

  typedef struct packed {
    logic [15:0]      near_latch_ms;
    logic [15:0]      beep_wait_ms;
    logic [15:0]      beep_len_ms;
    logic [15:0]      beep_stage_ms;
    logic [15:0]      beep_gap_slow_ms;
    logic [15:0]      led_real_period_ms;
    logic [15:0]      led_near_period_ms;
    logic [HoldW-1:0] ack_hold_ticks;
  } faa_cfg_t;

  typedef struct packed {
    logic             led;
    logic             buzzer;
    logic [1:0]       level;
    logic             ack;
    logic [TimeW-1:0] elapsed;
  } faa_mid_t;

endpackage

/* rtl/faa_cfg.sv */
// Configuration register file of the fall alert annunciator.
`timescale 1ns / 1ps

module faa_cfg import faa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output faa_cfg_t            cfg_o
);

  faa_cfg_t cfg_q;
  faa_cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NEAR_LATCH: cfg_d.near_latch_ms = cfg_data_i;
        CFG_BUZZ_DELAY: cfg_d.beep_wait_ms = cfg_data_i;
        CFG_BUZZ_ON:    cfg_d.beep_len_ms = cfg_data_i;
        CFG_BUZZ_STEP:  cfg_d.beep_stage_ms = cfg_data_i;
        CFG_BUZZ_SLOW:  cfg_d.beep_gap_slow_ms = cfg_data_i;
        CFG_LED_REAL:   cfg_d.led_real_period_ms = cfg_data_i;
        CFG_LED_NEAR:   cfg_d.led_near_period_ms = cfg_data_i;
        CFG_ACK_HOLD:   cfg_d.ack_hold_ticks = cfg_data_i[HoldW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_latch_ms      <= NEAR_LATCH_RST;
      cfg_q.beep_wait_ms       <= BUZZ_DELAY_RST;
      cfg_q.beep_len_ms        <= BUZZ_ON_RST;
      cfg_q.beep_stage_ms      <= BUZZ_STEP_RST;
      cfg_q.beep_gap_slow_ms   <= BUZZ_SLOW_RST;
      cfg_q.led_real_period_ms <= LED_REAL_RST;
      cfg_q.led_near_period_ms <= LED_NEAR_RST;
      cfg_q.ack_hold_ticks     <= ACK_HOLD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/faa_core.sv */
// Per-tick alert latch, LED and buzzer timing and button acknowledge logic.
`timescale 1ns / 1ps

module faa_core import faa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  faa_cfg_t         cfg_i,
  input  logic             step_i,
  input  logic [TimeW-1:0] now_i,
  input  logic [1:0]       req_i,
  input  logic             pressed_i,
  output faa_mid_t         mid_o
);

  logic [1:0]       level_q, level_d;
  logic [TimeW-1:0] ltime_q, ltime_d;
  logic             led_q, led_d;
  logic [TimeW-1:0] led_last_q, led_last_d;
  logic             buzz_q, buzz_d;
  logic [TimeW-1:0] buzz_last_q, buzz_last_d;
  logic             was_down_q, was_down_d;
  logic             armed_q, armed_d;
  logic [HoldW-1:0] count_q, count_d;

  always_comb begin
    logic [1:0]       lvl;
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] led_gap;
    logic [TimeW-1:0] buzz_gap;
    logic [TimeW-1:0] beep_time;
    logic [15:0]      period;
    logic [15:0]      off_gap;
    logic [HoldW-1:0] cnt_next;
    logic             ack;

    level_d     = level_q;
    ltime_d     = ltime_q;
    led_d       = led_q;
    led_last_d  = led_last_q;
    buzz_d      = buzz_q;
    buzz_last_d = buzz_last_q;
    was_down_d  = was_down_q;
    armed_d     = armed_q;
    count_d     = count_q;
    ack         = 1'b0;
    cnt_next    = count_q;

    lvl = level_q;
    if (req_i == EVT_REAL) begin
      if (level_q != LVL_REAL) begin
        lvl     = LVL_REAL;
        ltime_d = now_i;
      end
    end else if (req_i == EVT_NEAR && level_q == LVL_NONE) begin
      lvl     = LVL_NEAR;
      ltime_d = now_i;
    end

    elapsed = now_i - ltime_d;
    if (lvl == LVL_NEAR && elapsed > {16'd0, cfg_i.near_latch_ms}) begin
      lvl = LVL_NONE;
    end

    led_gap   = now_i - led_last_q;
    buzz_gap  = now_i - buzz_last_q;
    beep_time = elapsed - {16'd0, cfg_i.beep_wait_ms};
    period    = (lvl == LVL_REAL) ? cfg_i.led_real_period_ms : cfg_i.led_near_period_ms;

    if (beep_time < {16'd0, cfg_i.beep_stage_ms}) begin
      off_gap = cfg_i.beep_gap_slow_ms;
    end else if (beep_time < {15'd0, cfg_i.beep_stage_ms, 1'b0}) begin
      off_gap = OFF_MID_MS;
    end else begin
      off_gap = OFF_FAST_MS;
    end

    if (lvl == LVL_NONE) begin
      led_d = 1'b0;
    end else if (led_gap >= {16'd0, period}) begin
      led_d      = ~led_q;
      led_last_d = now_i;
    end

    if (lvl != LVL_REAL || elapsed < {16'd0, cfg_i.beep_wait_ms}) begin
      buzz_d = 1'b0;
    end else if (buzz_q) begin
      if (buzz_gap >= {16'd0, cfg_i.beep_len_ms}) begin
        buzz_d      = 1'b0;
        buzz_last_d = now_i;
      end
    end else if (buzz_gap >= {16'd0, off_gap}) begin
      buzz_d      = 1'b1;
      buzz_last_d = now_i;
    end

    if (lvl != LVL_REAL) begin
      was_down_d = 1'b0;
      armed_d    = 1'b0;
      count_d    = '0;
    end else if (pressed_i) begin
      if (!was_down_q) begin
        was_down_d = 1'b1;
        count_d    = HoldW'(1);
      end else if (armed_q) begin
        if (count_q < cfg_i.ack_hold_ticks) begin
          cnt_next = count_q + HoldW'(1);
        end
        count_d = cnt_next;
        if (cnt_next >= cfg_i.ack_hold_ticks) begin
          ack        = 1'b1;
          lvl        = LVL_NONE;
          was_down_d = 1'b0;
          armed_d    = 1'b0;
          count_d    = '0;
        end
      end
    end else begin
      was_down_d = 1'b0;
      count_d    = '0;
      armed_d    = 1'b1;
    end

    level_d = lvl;

    mid_o.led     = led_d;
    mid_o.buzzer  = buzz_d;
    mid_o.level   = lvl;
    mid_o.ack     = ack;
    mid_o.elapsed = elapsed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= LVL_NONE;
      ltime_q     <= '0;
      led_q       <= 1'b0;
      led_last_q  <= '0;
      buzz_q      <= 1'b0;
      buzz_last_q <= '0;
      was_down_q  <= 1'b0;
      armed_q     <= 1'b0;
      count_q     <= '0;
    end else if (step_i) begin
      level_q     <= level_d;
      ltime_q     <= ltime_d;
      led_q       <= led_d;
      led_last_q  <= led_last_d;
      buzz_q      <= buzz_d;
      buzz_last_q <= buzz_last_d;
      was_down_q  <= was_down_d;
      armed_q     <= armed_d;
      count_q     <= count_d;
    end
  end

endmodule

/* rtl/faa_secs.sv */
// Result register stage that converts the alert duration to whole seconds.
`timescale 1ns / 1ps

module faa_secs import faa_pkg::*; (
  input  logic             clk_i,
  input  faa_mid_t         mid_i,
  input  logic             load_i,
  output logic             led_o,
  output logic             buzzer_o,
  output logic [1:0]       alert_level_o,
  output logic             ack_o,
  output logic [SecsW-1:0] ack_seconds_o
);

  logic [ProdW-1:0] prod;
  logic [SecsW-1:0] secs_d;
  logic             led_q;
  logic             buzzer_q;
  logic [1:0]       level_q;
  logic             ack_q;
  logic [SecsW-1:0] secs_q;

  assign prod   = ProdW'(mid_i.elapsed) * ProdW'(DIV_MUL);
  assign secs_d = mid_i.ack ? prod[DivShift +: SecsW] : '0;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      led_q    <= mid_i.led;
      buzzer_q <= mid_i.buzzer;
      level_q  <= mid_i.level;
      ack_q    <= mid_i.ack;
      secs_q   <= secs_d;
    end
  end

  assign led_o         = led_q;
  assign buzzer_o      = buzzer_q;
  assign alert_level_o = level_q;
  assign ack_o         = ack_q;
  assign ack_seconds_o = secs_q;

endmodule

/* rtl/fall_alert_annunciator.sv */
// Top level of the fall alert annunciator: handshakes, tick pipeline and result stage.
`timescale 1ns / 1ps

// Each accepted item is one service tick. The block takes one item in every clock cycle while
// in_stall_o is low, and passes it on through three registers to the outputs: the tick
// is held in an input register, the alert, LED, buzzer and button state is updated in a single
// pass into a middle register, and the registered reciprocal multiplication that turns the
// alert duration into whole seconds fills the result register. Each stage moves on whenever
// the stage after it is empty or moving, so a stalled result holds back new items only once
// all three stages are full. Configuration registers may be written only while no item is in
// flight.

module fall_alert_annunciator import faa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [TimeW-1:0]    now_ms_i,
  input  logic [1:0]          event_req_i,
  input  logic                button_down_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                led_o,
  output logic                buzzer_o,
  output logic [1:0]          alert_level_o,
  output logic                ack_o,
  output logic [SecsW-1:0]    ack_seconds_o
);

  faa_cfg_t         cfg;
  faa_mid_t         mid_comb;
  faa_mid_t         mid_q;
  logic             in_v_q;
  logic             mid_v_q;
  logic             out_v_q;
  logic [TimeW-1:0] now_q;
  logic [1:0]       req_q;
  logic             btn_q;
  logic             out_ready;
  logic             mid_ready;
  logic             in_ready;
  logic             in_take;
  logic             step;
  logic             mid_move;

  assign out_ready = !out_v_q || !out_stall_i;
  assign mid_ready = !mid_v_q || out_ready;
  assign in_ready  = !in_v_q || mid_ready;
  assign in_take   = in_valid_i && in_ready;
  assign step      = in_v_q && mid_ready;
  assign mid_move  = mid_v_q && out_ready;

  faa_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      mid_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_q <= in_valid_i;
      end
      if (mid_ready) begin
        mid_v_q <= in_v_q;
      end
      if (out_ready) begin
        out_v_q <= mid_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      now_q <= now_ms_i;
      req_q <= event_req_i;
      btn_q <= button_down_i;
    end
    if (step) begin
      mid_q <= mid_comb;
    end
  end

  faa_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_i    (step),
    .now_i     (now_q),
    .req_i     (req_q),
    .pressed_i (btn_q),
    .mid_o     (mid_comb)
  );

  faa_secs u_secs (
    .clk_i         (clk_i),
    .mid_i         (mid_q),
    .load_i        (mid_move),
    .led_o         (led_o),
    .buzzer_o      (buzzer_o),
    .alert_level_o (alert_level_o),
    .ack_o         (ack_o),
    .ack_seconds_o (ack_seconds_o)
  );

  assign in_stall_o  = !in_ready;
  assign out_valid_o = out_v_q;

endmodule
